// File: rtl/core/lfr_pkg.sv
// Shared types and constants of the link frame receiver.
// Depends on nothing; imported by the receiver core.
package lfr_pkg;

	// Largest data field the design supports, before the register limit.
	localparam int MAX_DATA = 1024;

	// Field widths.
	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 11;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	// Hard cap on the data count: the smaller of MAX_DATA and what LEN_W holds.
	localparam logic [LEN_W-1:0] DATA_CAP =
		(MAX_DATA > (1 << LEN_W) - 1) ? {LEN_W{1'b1}} : LEN_W'(MAX_DATA);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STATION_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DATA_LEN    = 2'd1;

	// Line bytes.
	localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h5C;
	localparam logic [BYTE_W-1:0] ESC_BYTE  = 8'h5D;
	localparam logic [BYTE_W-1:0] ESC_FLAG  = 8'h7C;
	localparam logic [BYTE_W-1:0] ESC_ESC   = 8'h7D;

	// Control bytes.
	localparam logic [BYTE_W-1:0] CTL_I0   = 8'h80;
	localparam logic [BYTE_W-1:0] CTL_I1   = 8'hC0;
	localparam logic [BYTE_W-1:0] CTL_SET  = 8'h07;
	localparam logic [BYTE_W-1:0] CTL_DISC = 8'h0A;
	localparam logic [BYTE_W-1:0] CTL_UA   = 8'h06;
	localparam logic [BYTE_W-1:0] CTL_RR0  = 8'h11;
	localparam logic [BYTE_W-1:0] CTL_RR1  = 8'h01;
	localparam logic [BYTE_W-1:0] CTL_REJ0 = 8'h15;
	localparam logic [BYTE_W-1:0] CTL_REJ1 = 8'h05;

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESPONSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STATUS   = 2'd2;

	// Frame status codes.
	localparam logic [STATUS_W-1:0] STS_NONE   = 3'd0;
	localparam logic [STATUS_W-1:0] STS_GOOD_I = 3'd1;
	localparam logic [STATUS_W-1:0] STS_BAD_I  = 3'd2;
	localparam logic [STATUS_W-1:0] STS_SET    = 3'd3;
	localparam logic [STATUS_W-1:0] STS_DISC   = 3'd4;
	localparam logic [STATUS_W-1:0] STS_UA     = 3'd5;

	// Steps of a response frame followed by its status item.
	localparam logic [2:0] STEP_OPEN   = 3'd0;
	localparam logic [2:0] STEP_ADDR   = 3'd1;
	localparam logic [2:0] STEP_CTRL   = 3'd2;
	localparam logic [2:0] STEP_BCC    = 3'd3;
	localparam logic [2:0] STEP_CLOSE  = 3'd4;
	localparam logic [2:0] STEP_STATUS = 3'd5;

	// Result descriptor queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [5:0] {
		ST_HUNT = 6'b000001,
		ST_FLAG = 6'b000010,
		ST_ADDR = 6'b000100,
		ST_CTRL = 6'b001000,
		ST_SUP  = 6'b010000,
		ST_DATA = 6'b100000
	} parse_state_t;

	typedef enum logic [1:0] {
		DESC_PAYLOAD = 2'd0,
		DESC_FRAME   = 2'd1,
		DESC_STATUS  = 2'd2
	} desc_kind_t;

	// One entry per input byte that causes results.
	typedef struct packed {
		desc_kind_t          kind;
		logic [BYTE_W-1:0]   data;    // payload byte or response control
		logic [STATUS_W-1:0] status;
		logic                seq;
		logic [LEN_W-1:0]    len;
	} desc_t;

endpackage

// File: rtl/core/link_frame_receiver.sv
// Link frame receiver: flag hunt, header check, destuffing, BCC2 check, responses.
// Depends on lfr_pkg for types, codes and sizes.
//
// Raw line bytes enter on the in channel, one item per cycle at most. An accepted
// byte is registered, parsed against the frame state, and its results are queued
// as one descriptor in a four-entry queue, from which the first result passes into
// the output register. Data bytes of an I-frame are delivered one byte late, so
// BCC2 never shows as payload, and are delivered before the frame is checked: a bad
// status item tells the user to discard what came. A closing flag produces a five
// byte response frame (RR, REJ, UA or DISC) followed by a status item, six output
// items from the one output register; a received UA produces a status item only.
// Payload runs at one item per cycle in and out while out_ready stays high. The
// output sequencer is what sets the rate in bursts: the descriptor it walks stays
// at the head of the queue until its last result, so the queue absorbs up to three
// more descriptors behind it, and the input stalls only once the queue is full.
// The closing flag of a frame also opens the next one. Write station_address and
// max_data_len only while the block is idle.
module link_frame_receiver
	import lfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// received bytes
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BYTE_W-1:0]     rx_byte,
	// results
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [KIND_W-1:0]     out_kind,
	output logic [BYTE_W-1:0]     out_byte,
	output logic [STATUS_W-1:0]   frame_status,
	output logic                  seq_bit,
	output logic [LEN_W-1:0]      data_len,
	output logic                  last,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// ---------------------------------------------------------------- config
	logic [BYTE_W-1:0] station_q;
	logic [LEN_W-1:0]  max_len_q;
	logic [LEN_W-1:0]  limit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'h03;
			max_len_q <= 11'd255;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_STATION_ADDRESS: station_q <= cfg_data[BYTE_W-1:0];
				REG_MAX_DATA_LEN:    max_len_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective data limit: register value clamped to the design cap.
	assign limit = (max_len_q > DATA_CAP) ? DATA_CAP : max_len_q;

	// ---------------------------------------------------------- input stage
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              commit;

	logic [FIFO_AW:0]  fifo_cnt_q;
	logic              fifo_full;

	assign fifo_full = (fifo_cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
	// Hold the registered byte until the queue can take whatever it causes.
	assign commit    = valid_s1 && !fifo_full;
	assign in_ready  = !valid_s1 || commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// --------------------------------------------------------------- parser
	parse_state_t      state_q, state_d;
	logic [BYTE_W-1:0] control_q, control_d;
	logic [BYTE_W-1:0] held_q, held_d;
	logic              held_valid_q, held_valid_d;
	logic              esc_q, esc_d;
	logic [BYTE_W-1:0] xor_q, xor_d;
	logic [LEN_W-1:0]  count_q, count_d;
	logic              overlong_q, overlong_d;

	logic              push_en;
	desc_t             push_desc;

	logic              take_en;
	logic [BYTE_W-1:0] take_byte;
	logic              is_iframe;
	logic              seq;
	logic              good;

	assign is_iframe = (control_q == CTL_I0) || (control_q == CTL_I1);
	assign seq       = (control_q == CTL_I1);
	assign good      = held_valid_q && !esc_q && !overlong_q &&
	                   (count_q != '0) && (xor_q == held_q);

	always_comb begin
		state_d      = state_q;
		control_d    = control_q;
		held_d       = held_q;
		held_valid_d = held_valid_q;
		esc_d        = esc_q;
		xor_d        = xor_q;
		count_d      = count_q;
		overlong_d   = overlong_q;
		push_en      = 1'b0;
		push_desc    = '{kind: DESC_PAYLOAD, data: '0, status: STS_NONE,
		                 seq: 1'b0, len: '0};
		take_en      = 1'b0;
		take_byte    = byte_s1;

		case (state_q)
			ST_HUNT: begin
				if (byte_s1 == FLAG_BYTE) state_d = ST_FLAG;
			end
			ST_FLAG: begin
				if (byte_s1 == station_q)      state_d = ST_ADDR;
				else if (byte_s1 != FLAG_BYTE) state_d = ST_HUNT;
			end
			ST_ADDR: begin
				if (byte_s1 == CTL_I0 || byte_s1 == CTL_I1 || byte_s1 == CTL_SET ||
				    byte_s1 == CTL_DISC || byte_s1 == CTL_UA) begin
					control_d = byte_s1;
					state_d   = ST_CTRL;
				end else if (byte_s1 == FLAG_BYTE) begin
					state_d = ST_FLAG;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_CTRL: begin
				if (byte_s1 == (station_q ^ control_q)) begin
					if (is_iframe) begin
						held_d       = '0;
						held_valid_d = 1'b0;
						esc_d        = 1'b0;
						xor_d        = '0;
						count_d      = '0;
						overlong_d   = 1'b0;
						state_d      = ST_DATA;
					end else begin
						state_d = ST_SUP;
					end
				end else if (byte_s1 == FLAG_BYTE) begin
					state_d = ST_FLAG;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_SUP: begin
				if (byte_s1 == FLAG_BYTE) begin
					push_en = 1'b1;
					if (control_q == CTL_SET) begin
						push_desc.kind   = DESC_FRAME;
						push_desc.data   = CTL_UA;
						push_desc.status = STS_SET;
					end else if (control_q == CTL_DISC) begin
						push_desc.kind   = DESC_FRAME;
						push_desc.data   = CTL_DISC;
						push_desc.status = STS_DISC;
					end else begin
						push_desc.kind   = DESC_STATUS;
						push_desc.status = STS_UA;
					end
					state_d = ST_FLAG;
				end else begin
					state_d = ST_HUNT;
				end
			end
			ST_DATA: begin
				if (byte_s1 == FLAG_BYTE) begin
					// Close the I-frame: answer RR or REJ, then report.
					push_en          = 1'b1;
					push_desc.kind   = DESC_FRAME;
					push_desc.data   = seq ? (good ? CTL_RR1 : CTL_REJ1)
					                       : (good ? CTL_RR0 : CTL_REJ0);
					push_desc.status = good ? STS_GOOD_I : STS_BAD_I;
					push_desc.seq    = seq;
					push_desc.len    = count_q;
					state_d          = ST_FLAG;
				end else if (esc_q) begin
					esc_d = 1'b0;
					if (byte_s1 == ESC_FLAG) begin
						take_en   = 1'b1;
						take_byte = FLAG_BYTE;
					end else if (byte_s1 == ESC_ESC) begin
						take_en   = 1'b1;
						take_byte = ESC_BYTE;
					end
				end else if (byte_s1 == ESC_BYTE) begin
					esc_d = 1'b1;
				end else begin
					take_en = 1'b1;
				end
			end
			default: begin
				state_d = ST_HUNT;
			end
		endcase

		// Release the held byte as payload, or drop it past the limit.
		if (take_en) begin
			if (held_valid_q) begin
				if (count_q < limit) begin
					push_en        = 1'b1;
					push_desc.kind = DESC_PAYLOAD;
					push_desc.data = held_q;
					xor_d          = xor_q ^ held_q;
					count_d        = count_q + 1'b1;
				end else begin
					overlong_d = 1'b1;
				end
			end
			held_d       = take_byte;
			held_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HUNT;
			control_q    <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			esc_q        <= 1'b0;
			xor_q        <= '0;
			count_q      <= '0;
			overlong_q   <= 1'b0;
		end else if (commit) begin
			state_q      <= state_d;
			control_q    <= control_d;
			held_q       <= held_d;
			held_valid_q <= held_valid_d;
			esc_q        <= esc_d;
			xor_q        <= xor_d;
			count_q      <= count_d;
			overlong_q   <= overlong_d;
		end
	end

	// ------------------------------------------------------ descriptor queue
	desc_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic               push, pop;
	desc_t              head;

	assign push = commit && push_en;
	assign head = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + 1'b1;
				2'b01:   fifo_cnt_q <= fifo_cnt_q - 1'b1;
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
		end
	end

	// ------------------------------------------------------ output sequencer
	logic [2:0]          step_q;
	logic                emit;
	logic                final_step;
	logic [KIND_W-1:0]   gen_kind;
	logic [BYTE_W-1:0]   gen_byte;
	logic [STATUS_W-1:0] gen_status;
	logic                gen_seq;
	logic [LEN_W-1:0]    gen_len;

	logic                out_valid_q;
	logic [KIND_W-1:0]   kind_q;
	logic [BYTE_W-1:0]   byte_q;
	logic [STATUS_W-1:0] status_q;
	logic                seq_q;
	logic [LEN_W-1:0]    len_q;
	logic                last_q;

	assign emit = (fifo_cnt_q != '0) && (!out_valid_q || out_ready);
	assign pop  = emit && final_step;

	// Walk the head descriptor one result per cycle while the output register can take one.
	always_comb begin
		gen_kind   = KIND_STATUS;
		gen_byte   = '0;
		gen_status = head.status;
		gen_seq    = head.seq;
		gen_len    = head.len;
		final_step = 1'b1;
		case (head.kind)
			DESC_PAYLOAD: begin
				gen_kind   = KIND_PAYLOAD;
				gen_byte   = head.data;
				gen_status = STS_NONE;
				gen_seq    = 1'b0;
				gen_len    = '0;
			end
			DESC_FRAME: begin
				if (step_q != STEP_STATUS) begin
					gen_kind   = KIND_RESPONSE;
					gen_status = STS_NONE;
					gen_seq    = 1'b0;
					gen_len    = '0;
					final_step = 1'b0;
				end
				case (step_q)
					STEP_OPEN:  gen_byte = FLAG_BYTE;
					STEP_ADDR:  gen_byte = station_q;
					STEP_CTRL:  gen_byte = head.data;
					STEP_BCC:   gen_byte = station_q ^ head.data;
					STEP_CLOSE: gen_byte = FLAG_BYTE;
					default:    gen_byte = '0;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_OPEN;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				step_q <= final_step ? STEP_OPEN : step_q + 1'b1;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q   <= gen_kind;
			byte_q   <= gen_byte;
			status_q <= gen_status;
			seq_q    <= gen_seq;
			len_q    <= gen_len;
			last_q   <= final_step;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = kind_q;
	assign out_byte     = byte_q;
	assign frame_status = status_q;
	assign seq_bit      = seq_q;
	assign data_len     = len_q;
	assign last         = last_q;

	// ----------------------------------------------------------- assertions
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("descriptor queue count past its depth");

	a_step_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != STEP_OPEN) |-> (fifo_cnt_q != '0))
		else $error("frame walk in progress with an empty queue");

	a_response_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_kind == KIND_RESPONSE) |-> (!last && frame_status == STS_NONE))
		else $error("response byte flagged last or carrying status");

	a_single_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == KIND_PAYLOAD || out_kind == KIND_STATUS)) |-> last)
		else $error("payload or status item not flagged last");

endmodule
